### rtl/core/bpc_pkg.sv
// package for the boolean parenthesization counter
// types, constants and command struct shared by all rtl/core files except bpc_ram
package bpc_pkg;

  localparam int MAX_LEN = 63;
  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int WAYS_W = 54;
  localparam int HALF_W = WAYS_W / 2;
  localparam int TAB_DEPTH = 1 << (2 * IDX_W);
  localparam int TAB_AW = 2 * IDX_W;
  localparam int TAB_W = 2 * WAYS_W;

  localparam logic [7:0] SYM_T = 8'h54;
  localparam logic [7:0] SYM_F = 8'h46;
  localparam logic [7:0] SYM_AND = 8'h26;
  localparam logic [7:0] SYM_OR = 8'h7c;

  localparam logic [1:0] PROD_P = 2'd0;
  localparam logic [1:0] PROD_Q = 2'd1;
  localparam logic [1:0] PROD_S = 2'd2;

  localparam logic [1:0] PART_LL = 2'd0;
  localparam logic [1:0] PART_HL = 2'd1;
  localparam logic [1:0] PART_LH = 2'd2;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_symbol;
  } in_t;

  typedef struct packed {
    logic [WAYS_W-1:0] true_ways;
    logic [WAYS_W-1:0] false_ways;
    logic              too_long;
  } res_t;

  typedef struct packed {
    logic [WAYS_W-1:0] tw;
    logic [WAYS_W-1:0] fw;
  } tab_t;

  typedef struct packed {
    logic              sym_we;
    logic [IDX_W-1:0]  sym_addr;
    logic [TAB_AW-1:0] tab_raddr;
    logic              tab_we;
    logic [TAB_AW-1:0] tab_waddr;
    logic              leaf_load;
    logic              cap_left;
    logic              cap_right;
    logic              acc_clear;
    logic              mul_go;
    logic [1:0]        mul_prod;
    logic [1:0]        mul_part;
    logic              sum_go;
    logic              res_go;
    logic              res_ovf;
  } cmd_t;

endpackage

### rtl/core/bpc_ram.sv
// generic single write port ram with registered read
// no dependencies
module bpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/bpc_datapath.sv
// datapath: symbol store, interval tables, split-product multiplier, accumulators
// depends on bpc_pkg and bpc_ram
module bpc_datapath
  import bpc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic [7:0] sym_i,
  output res_t       res_o,
  output logic       done_o
);

  logic [7:0]        sym_rd;
  tab_t              tab_rd;
  tab_t              tab_wr;
  logic [7:0]        op_q;
  logic [WAYS_W-1:0] lt_q, lf_q, rt_q, rf_q, ls_q, rs_q;
  logic [WAYS_W-1:0] t_q, f_q;
  logic [WAYS_W-1:0] pp_q;
  logic              pv_q;
  logic [1:0]        pprod_q, ppart_q;
  logic [WAYS_W-1:0] prod_q [3];
  logic [WAYS_W-1:0] op_a, op_b;
  logic [HALF_W-1:0] ma, mb;
  logic [WAYS_W-1:0] p_w, q_w, s_w;
  res_t              res_q;
  logic              done_q;

  bpc_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_sym_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.sym_we),
    .waddr_i(cmd_i.sym_addr),
    .wdata_i(sym_i),
    .raddr_i(cmd_i.sym_addr),
    .rdata_o(sym_rd)
  );

  assign tab_wr.tw = t_q;
  assign tab_wr.fw = f_q;

  bpc_ram #(.WIDTH(TAB_W), .DEPTH(TAB_DEPTH)) u_tab_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.tab_we),
    .waddr_i(cmd_i.tab_waddr),
    .wdata_i(tab_wr),
    .raddr_i(cmd_i.tab_raddr),
    .rdata_o(tab_rd)
  );

  // operand select for the 27x27 partial product
  always_comb begin
    case (cmd_i.mul_prod)
      PROD_P: begin
        op_a = lt_q;
        op_b = rt_q;
      end
      PROD_Q: begin
        op_a = lf_q;
        op_b = rf_q;
      end
      default: begin
        op_a = ls_q;
        op_b = rs_q;
      end
    endcase
    case (cmd_i.mul_part)
      PART_HL: begin
        ma = op_a[WAYS_W-1:HALF_W];
        mb = op_b[HALF_W-1:0];
      end
      PART_LH: begin
        ma = op_a[HALF_W-1:0];
        mb = op_b[WAYS_W-1:HALF_W];
      end
      default: begin
        ma = op_a[HALF_W-1:0];
        mb = op_b[HALF_W-1:0];
      end
    endcase
  end

  assign p_w = prod_q[PROD_P];
  assign q_w = prod_q[PROD_Q];
  assign s_w = prod_q[PROD_S];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_left) begin
      op_q <= sym_rd;
      lt_q <= tab_rd.tw;
      lf_q <= tab_rd.fw;
    end
    if (cmd_i.cap_right) begin
      rt_q <= tab_rd.tw;
      rf_q <= tab_rd.fw;
      rs_q <= tab_rd.tw + tab_rd.fw;
      ls_q <= lt_q + lf_q;
    end
    pp_q    <= ma * mb;
    pprod_q <= cmd_i.mul_prod;
    ppart_q <= cmd_i.mul_part;
    if (pv_q) begin
      if (ppart_q == PART_LL) begin
        prod_q[pprod_q] <= pp_q;
      end else begin
        prod_q[pprod_q] <= prod_q[pprod_q] + {pp_q[HALF_W-1:0], {HALF_W{1'b0}}};
      end
    end
    if (cmd_i.leaf_load) begin
      t_q <= WAYS_W'(sym_rd == SYM_T);
      f_q <= WAYS_W'(sym_rd == SYM_F);
    end else if (cmd_i.acc_clear) begin
      t_q <= '0;
      f_q <= '0;
    end else if (cmd_i.sum_go) begin
      case (op_q)
        SYM_AND: begin
          t_q <= t_q + p_w;
          f_q <= f_q + s_w - p_w;
        end
        SYM_OR: begin
          t_q <= t_q + s_w - q_w;
          f_q <= f_q + q_w;
        end
        default: begin
          t_q <= t_q + s_w - p_w - q_w;
          f_q <= f_q + p_w + q_w;
        end
      endcase
    end
    if (cmd_i.res_go) begin
      res_q.too_long   <= cmd_i.res_ovf;
      res_q.true_ways  <= cmd_i.res_ovf ? '0 : t_q;
      res_q.false_ways <= cmd_i.res_ovf ? '0 : f_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      pv_q   <= cmd_i.mul_go;
      done_q <= cmd_i.res_go;
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

### rtl/core/bpc_ctrl.sv
// controller: load counter, interval and split sequencer
// depends on bpc_pkg
module bpc_ctrl
  import bpc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  logic last_i,
  output logic busy,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_NEXT, ST_LEAF_RD, ST_LEAF_LD, ST_RD_L, ST_RD_R, ST_CAP,
    ST_MUL, ST_DRAIN, ST_SUM, ST_WR, ST_DONE
  } state_e;

  state_e           state_q;
  logic [LEN_W-1:0] cnt_q, len_q;
  logic             ovf_q;
  logic [IDX_W-1:0] i_q, k_q, j_w, km1_w, kp1_w;
  logic [1:0]       mprod_q, mpart_q;
  logic             accept;
  logic             full;

  assign accept = start && (state_q == ST_IDLE);
  assign full   = (cnt_q == LEN_W'(MAX_LEN));
  assign j_w    = IDX_W'({1'b0, i_q} + len_q - LEN_W'(1));
  assign km1_w  = k_q - IDX_W'(1);
  assign kp1_w  = k_q + IDX_W'(1);
  assign busy   = (state_q != ST_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_prod = mprod_q;
    cmd_o.mul_part = mpart_q;
    cmd_o.tab_waddr = {i_q, j_w};
    case (state_q)
      ST_IDLE: begin
        cmd_o.sym_addr = cnt_q[IDX_W-1:0];
        cmd_o.sym_we   = accept && !full;
        cmd_o.res_go   = accept && last_i && (ovf_q || full);
        cmd_o.res_ovf  = 1'b1;
      end
      ST_NEXT:    cmd_o.acc_clear = 1'b1;
      ST_LEAF_RD: cmd_o.sym_addr = i_q;
      ST_LEAF_LD: cmd_o.leaf_load = 1'b1;
      ST_RD_L: begin
        cmd_o.sym_addr  = k_q;
        cmd_o.tab_raddr = {i_q, km1_w};
      end
      ST_RD_R: begin
        cmd_o.cap_left  = 1'b1;
        cmd_o.tab_raddr = {kp1_w, j_w};
      end
      ST_CAP:  cmd_o.cap_right = 1'b1;
      ST_MUL:  cmd_o.mul_go = 1'b1;
      ST_SUM:  cmd_o.sum_go = 1'b1;
      ST_WR:   cmd_o.tab_we = 1'b1;
      ST_DONE: cmd_o.res_go = 1'b1;
      default: cmd_o.acc_clear = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      len_q   <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      k_q     <= '0;
      mprod_q <= PROD_P;
      mpart_q <= PART_LL;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (last_i) begin
              if (ovf_q || full) begin
                cnt_q <= '0;
                ovf_q <= 1'b0;
              end else begin
                cnt_q   <= cnt_q + LEN_W'(1);
                len_q   <= LEN_W'(1);
                i_q     <= '0;
                state_q <= ST_NEXT;
              end
            end else if (full) begin
              ovf_q <= 1'b1;
            end else begin
              cnt_q <= cnt_q + LEN_W'(1);
            end
          end
        end
        ST_NEXT: begin
          k_q <= i_q + IDX_W'(1);
          if (len_q == LEN_W'(1)) begin
            state_q <= ST_LEAF_RD;
          end else if ({1'b0, i_q} + LEN_W'(2) <= {1'b0, j_w}) begin
            state_q <= ST_RD_L;
          end else begin
            state_q <= ST_WR;
          end
        end
        ST_LEAF_RD: state_q <= ST_LEAF_LD;
        ST_LEAF_LD: state_q <= ST_WR;
        ST_RD_L:    state_q <= ST_RD_R;
        ST_RD_R:    state_q <= ST_CAP;
        ST_CAP: begin
          mprod_q <= PROD_P;
          mpart_q <= PART_LL;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          if (mpart_q == PART_LH) begin
            mpart_q <= PART_LL;
            if (mprod_q == PROD_S) begin
              state_q <= ST_DRAIN;
            end else begin
              mprod_q <= mprod_q + 2'd1;
            end
          end else begin
            mpart_q <= mpart_q + 2'd1;
          end
        end
        ST_DRAIN: state_q <= ST_SUM;
        ST_SUM: begin
          k_q <= k_q + IDX_W'(2);
          if ({1'b0, k_q} + LEN_W'(3) <= {1'b0, j_w}) begin
            state_q <= ST_RD_L;
          end else begin
            state_q <= ST_WR;
          end
        end
        ST_WR: begin
          if ({1'b0, i_q} + len_q < cnt_q) begin
            i_q     <= i_q + IDX_W'(1);
            state_q <= ST_NEXT;
          end else if (len_q < cnt_q) begin
            len_q   <= len_q + LEN_W'(1);
            i_q     <= '0;
            state_q <= ST_NEXT;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          cnt_q   <= '0;
          ovf_q   <= 1'b0;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/boolean_parenthesization_count.sv
// top level of the boolean parenthesization counter
// depends on bpc_pkg, bpc_ctrl, bpc_datapath
//
// Each word is one symbol of an alternating operand/operator expression; a word
// that is not marked last is stored (up to 63 of them) when taken with start
// high, and busy stays low. After the last word of an expression of at most 63
// symbols, busy is high while the interval tables are filled, one split point
// at a time through a single 27x27 multiplier. The result is shown for one
// cycle with done_o high and cannot be held off. An expression over 63 symbols
// returns too_long in the cycle after its last word is taken, with zero counts.
module boolean_parenthesization_count
  import bpc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  in_i,
  output logic done_o,
  output res_t res_o
);

  cmd_t cmd;

  bpc_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .last_i(in_i.last_symbol),
    .busy  (busy),
    .cmd_o (cmd)
  );

  bpc_datapath u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .sym_i (in_i.symbol),
    .res_o (res_o),
    .done_o(done_o)
  );

endmodule

### rtl/core/bpc_checker.sv
// port-level checks for the boolean parenthesization counter
// depends on bpc_pkg; bound to boolean_parenthesization_count
module bpc_checker
  import bpc_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input in_t  in_i,
  input logic done_o,
  input res_t res_o
);

  a_long_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.too_long |-> res_o.true_ways == '0 && res_o.false_ways == '0)
    else $error("too_long result with nonzero counts");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  a_fill_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.too_long |-> $past(busy))
    else $error("counted result without a fill");

  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start) && $past(in_i.last_symbol))
    else $error("busy without a last word");

endmodule

bind boolean_parenthesization_count bpc_checker u_bpc_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .in_i  (in_i),
  .done_o(done_o),
  .res_o (res_o)
);

### verif/testbench.sv
// self-checking testbench for boolean_parenthesization_count
// depends on bpc_pkg and the rtl/core sources; checks every result word
`timescale 1ns / 100ps

module testbench;
  import bpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_t  in_i;
  logic done_o;
  res_t res_o;

  boolean_parenthesization_count dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .in_i  (in_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  logic [7:0]  expr_syms [MAX_LEN];
  int unsigned expr_len;
  bit          expr_ovf;
  res_t        pending_counts [$];
  int unsigned idle_pct;
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned overflow_results;
  int unsigned mismatches;
  int unsigned stall_cycles;
  logic [63:0] true_cnt  [MAX_LEN][MAX_LEN];
  logic [63:0] false_cnt [MAX_LEN][MAX_LEN];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic res_t count_groupings(int unsigned n);
    res_t        r;
    logic [63:0] t, f, lt, lf, rt, rf;
    int unsigned j;
    for (int unsigned ln = 1; ln <= n; ln++) begin
      for (int unsigned i = 0; i + ln <= n; i++) begin
        j = i + ln - 1;
        t = '0;
        f = '0;
        if (ln == 1) begin
          t = (expr_syms[i] == SYM_T) ? 64'd1 : 64'd0;
          f = (expr_syms[i] == SYM_F) ? 64'd1 : 64'd0;
        end else begin
          for (int unsigned k = i + 1; k + 1 <= j; k += 2) begin
            lt = true_cnt[i][k-1];
            lf = false_cnt[i][k-1];
            rt = true_cnt[k+1][j];
            rf = false_cnt[k+1][j];
            if (expr_syms[k] == SYM_AND) begin
              t += lt * rt;
              f += lf * rt + lt * rf + lf * rf;
            end else if (expr_syms[k] == SYM_OR) begin
              t += lf * rt + lt * rf + lt * rt;
              f += lf * rf;
            end else begin
              t += lf * rt + lt * rf;
              f += lf * rf + lt * rt;
            end
          end
        end
        true_cnt[i][j]  = t & ((64'd1 << WAYS_W) - 1);
        false_cnt[i][j] = f & ((64'd1 << WAYS_W) - 1);
      end
    end
    r.true_ways  = true_cnt[0][n-1][WAYS_W-1:0];
    r.false_ways = false_cnt[0][n-1][WAYS_W-1:0];
    r.too_long   = 1'b0;
    return r;
  endfunction

  function automatic void take_symbol(logic [7:0] s, logic fin);
    res_t r;
    if (expr_len < MAX_LEN) begin
      expr_syms[expr_len] = s;
      expr_len++;
    end else begin
      expr_ovf = 1'b1;
    end
    if (fin) begin
      if (expr_ovf) begin
        r = '0;
        r.too_long = 1'b1;
      end else begin
        r = count_groupings(expr_len);
      end
      pending_counts.push_back(r);
      expr_len = 0;
      expr_ovf = 1'b0;
    end
  endfunction

  // called and returns at a falling edge
  task automatic send_word(logic [7:0] s, logic fin);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start <= 1'b1;
    in_i  <= '{symbol: s, last_symbol: fin};
    do @(posedge clk_i); while (busy);
    take_symbol(s, fin);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_counts.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_operand(bit clean);
    if (!clean && $urandom_range(9) == 0) return 8'($urandom);
    return $urandom_range(1) ? SYM_T : SYM_F;
  endfunction

  function automatic logic [7:0] pick_operator(bit clean);
    case ($urandom_range(clean ? 2 : 3))
      0: return SYM_AND;
      1: return SYM_OR;
      2: return 8'h5e;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_expr(int unsigned n, bit clean);
    logic [7:0] s;
    for (int unsigned p = 0; p < n; p++) begin
      if (!clean && $urandom_range(7) == 0) s = 8'($urandom);
      else s = (p % 2 == 0) ? pick_operand(clean) : pick_operator(clean);
      send_word(s, p == n - 1);
    end
  endtask

  task automatic send_text(string txt);
    for (int p = 0; p < txt.len(); p++) send_word(txt[p], p == txt.len() - 1);
  endtask

  task automatic test_directed();
    idle_pct = 0;
    send_text("T");
    send_text("F");
    send_text("x");
    send_text("T&F");
    send_text("T|F");
    send_text("T^T");
    send_text("F|F&T");
    send_text("T&");
    send_text("&T|");
    send_word(8'hff, 1'b1);
    send_word(8'h00, 1'b1);
    drain_results();
  endtask

  task automatic test_longest();
    idle_pct = 9;
    send_expr(MAX_LEN, 1'b1);
    drain_results();
  endtask

  task automatic test_overflow();
    idle_pct = 0;
    send_expr(MAX_LEN + 1, 1'b1);
    send_expr(MAX_LEN + 7, 1'b0);
    send_text("T|T");
    drain_results();
  endtask

  task automatic test_random(int unsigned pct, int unsigned words);
    int unsigned goal, n;
    idle_pct = pct;
    goal = words_sent + words;
    while (words_sent < goal) begin
      n = $urandom_range(9) == 0 ? $urandom_range(1, 21) : $urandom_range(1, 13);
      if ($urandom_range(3) != 0 && n % 2 == 0) n++;
      send_expr(n, $urandom_range(4) != 0);
      if ($urandom_range(19) == 0) drain_results();
    end
    drain_results();
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (res_o.too_long) overflow_results++;
      if (pending_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", res_o);
      end else begin
        want = pending_counts.pop_front();
        if (res_o.true_ways !== want.true_ways || res_o.false_ways !== want.false_ways ||
            res_o.too_long !== want.too_long) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected t=%0d f=%0d long=%0b, got t=%0d f=%0d long=%0b",
                     want.true_ways, want.false_ways, want.too_long,
                     res_o.true_ways, res_o.false_ways, res_o.too_long);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", pending_counts.size());
      $display("boolean_parenthesization_count regression: fail");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    in_i = '0;
    expr_len = 0;
    expr_ovf = 1'b0;
    words_sent = 0;
    results_seen = 0;
    overflow_results = 0;
    mismatches = 0;
    stall_cycles = 0;
    idle_pct = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_longest();
    test_overflow();
    test_random(0, 230);
    test_random(69, 230);
    test_random(0, 230);
    test_random(9, 230);
    repeat (40) @(negedge clk_i);
    $display("covered %0d words, %0d results (%0d overlong), directed, longest and random",
             words_sent, results_seen, overflow_results);
    $display("%0d mismatches, %0d results left unmatched", mismatches, pending_counts.size());
    if (mismatches == 0 && pending_counts.size() == 0)
      $display("boolean_parenthesization_count regression: pass");
    else
      $display("boolean_parenthesization_count regression: fail");
    $finish;
  end

endmodule
